FILE: design/air_quality_level_classifier_assert.svh
// Assertion macros shared by the air quality level classifier.
`ifndef AIR_QUALITY_LEVEL_CLASSIFIER_ASSERT_SVH
`define AIR_QUALITY_LEVEL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AQLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define AQLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/aqlc_pkg.sv
// Types and constants of the air quality level classifier.
package aqlc_pkg;

	localparam int unsigned APB_AW = 5;
	localparam int unsigned SCORE_W = 14;
	localparam int unsigned RAW_W = 20;

	localparam logic OP_READING = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [2:0] REG_CO_MODERATE_ON = 3'd0;
	localparam logic [2:0] REG_CO_POOR_ON = 3'd1;
	localparam logic [2:0] REG_CO_HAZARD_ON = 3'd2;
	localparam logic [2:0] REG_CO_POOR_OFF = 3'd3;
	localparam logic [2:0] REG_AQI_MODERATE_ON = 3'd4;
	localparam logic [2:0] REG_AQI_POOR_ON = 3'd5;
	localparam logic [2:0] REG_AQI_HAZARD_ON = 3'd6;
	localparam logic [2:0] REG_AQI_POOR_OFF = 3'd7;

	localparam logic [SCORE_W-1:0] RST_CO_MODERATE_ON = 14'd3000;
	localparam logic [SCORE_W-1:0] RST_CO_POOR_ON = 14'd5000;
	localparam logic [SCORE_W-1:0] RST_CO_HAZARD_ON = 14'd7500;
	localparam logic [SCORE_W-1:0] RST_CO_POOR_OFF = 14'd4500;
	localparam logic [SCORE_W-1:0] RST_AQI_MODERATE_ON = 14'd5000;
	localparam logic [SCORE_W-1:0] RST_AQI_POOR_ON = 14'd9000;
	localparam logic [SCORE_W-1:0] RST_AQI_HAZARD_ON = 14'd15000;
	localparam logic [SCORE_W-1:0] RST_AQI_POOR_OFF = 14'd8000;

	localparam logic signed [RAW_W-1:0] TEMP_REF = 20'sd20;
	localparam logic [6:0] HUM_CO_REF = 7'd60;
	localparam logic signed [RAW_W-1:0] HUM_AQI_REF = 20'sd50;
	localparam logic signed [RAW_W-1:0] CO_PPM_GAIN = 20'sd50;
	localparam logic signed [RAW_W-1:0] CO_TEMP_GAIN = 20'sd5;
	localparam logic signed [RAW_W-1:0] CO_HUM_GAIN = 20'sd2;
	localparam logic signed [RAW_W-1:0] CO_OFFSET = 20'sd500;
	localparam logic signed [RAW_W-1:0] AQI_GAIN = 20'sd40;
	localparam logic signed [RAW_W-1:0] AQI_TEMP_GAIN = 20'sd3;
	localparam logic signed [RAW_W-1:0] AQI_HUM_GAIN = 20'sd2;
	localparam logic signed [RAW_W-1:0] AQI_OFFSET = 20'sd300;
	localparam logic signed [RAW_W-1:0] CO_RISK_MAX = 20'sd10000;
	localparam logic signed [RAW_W-1:0] AQI_RISK_MAX = 20'sd15000;

	typedef enum logic [1:0] {
		LVL_GOOD = 2'd0,
		LVL_MODERATE = 2'd1,
		LVL_POOR = 2'd2,
		LVL_HAZARD = 2'd3
	} aqlc_level_t;

	typedef struct packed {
		logic op;
		logic [11:0] co_ppm;
		logic [9:0] aqi_value;
		logic signed [7:0] temp_c;
		logic [6:0] hum_pct;
	} aqlc_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] co;
		logic [SCORE_W-1:0] aqi;
	} aqlc_score_t;

	typedef struct packed {
		logic [SCORE_W-1:0] co_moderate_on;
		logic [SCORE_W-1:0] co_poor_on;
		logic [SCORE_W-1:0] co_hazard_on;
		logic [SCORE_W-1:0] co_poor_off;
		logic [SCORE_W-1:0] aqi_moderate_on;
		logic [SCORE_W-1:0] aqi_poor_on;
		logic [SCORE_W-1:0] aqi_hazard_on;
		logic [SCORE_W-1:0] aqi_poor_off;
	} aqlc_thr_t;

endpackage

FILE: design/aqlc_if.sv
// Handshake interfaces for reading items and result items.
interface aqlc_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [11:0] co_ppm;
	logic [9:0] aqi_value;
	logic signed [7:0] temp_c;
	logic [6:0] hum_pct;

	modport source (output valid, op, co_ppm, aqi_value, temp_c, hum_pct, input ready);
	modport sink (input valid, op, co_ppm, aqi_value, temp_c, hum_pct, output ready);
endinterface

interface aqlc_out_if;
	logic valid;
	logic ready;
	logic [1:0] air_level;
	logic buzzer_on;
	logic [13:0] co_risk;
	logic [13:0] aqi_risk;

	modport source (output valid, air_level, buzzer_on, co_risk, aqi_risk, input ready);
	modport sink (input valid, air_level, buzzer_on, co_risk, aqi_risk, output ready);
endinterface

FILE: design/aqlc_regs.sv
// APB threshold register file of the air quality level classifier.
module aqlc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aqlc_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output aqlc_pkg::aqlc_thr_t           thr
);

	aqlc_pkg::aqlc_thr_t thr_q;
	logic [2:0] reg_idx;
	logic [aqlc_pkg::SCORE_W-1:0] rd_val;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite && pready;
	assign thr = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.co_moderate_on <= aqlc_pkg::RST_CO_MODERATE_ON;
			thr_q.co_poor_on <= aqlc_pkg::RST_CO_POOR_ON;
			thr_q.co_hazard_on <= aqlc_pkg::RST_CO_HAZARD_ON;
			thr_q.co_poor_off <= aqlc_pkg::RST_CO_POOR_OFF;
			thr_q.aqi_moderate_on <= aqlc_pkg::RST_AQI_MODERATE_ON;
			thr_q.aqi_poor_on <= aqlc_pkg::RST_AQI_POOR_ON;
			thr_q.aqi_hazard_on <= aqlc_pkg::RST_AQI_HAZARD_ON;
			thr_q.aqi_poor_off <= aqlc_pkg::RST_AQI_POOR_OFF;
		end else if (wr_en) begin
			case (reg_idx)
				aqlc_pkg::REG_CO_MODERATE_ON: thr_q.co_moderate_on <= pwdata[13:0];
				aqlc_pkg::REG_CO_POOR_ON: thr_q.co_poor_on <= pwdata[13:0];
				aqlc_pkg::REG_CO_HAZARD_ON: thr_q.co_hazard_on <= pwdata[13:0];
				aqlc_pkg::REG_CO_POOR_OFF: thr_q.co_poor_off <= pwdata[13:0];
				aqlc_pkg::REG_AQI_MODERATE_ON: thr_q.aqi_moderate_on <= pwdata[13:0];
				aqlc_pkg::REG_AQI_POOR_ON: thr_q.aqi_poor_on <= pwdata[13:0];
				aqlc_pkg::REG_AQI_HAZARD_ON: thr_q.aqi_hazard_on <= pwdata[13:0];
				aqlc_pkg::REG_AQI_POOR_OFF: thr_q.aqi_poor_off <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			aqlc_pkg::REG_CO_MODERATE_ON: rd_val = thr_q.co_moderate_on;
			aqlc_pkg::REG_CO_POOR_ON: rd_val = thr_q.co_poor_on;
			aqlc_pkg::REG_CO_HAZARD_ON: rd_val = thr_q.co_hazard_on;
			aqlc_pkg::REG_CO_POOR_OFF: rd_val = thr_q.co_poor_off;
			aqlc_pkg::REG_AQI_MODERATE_ON: rd_val = thr_q.aqi_moderate_on;
			aqlc_pkg::REG_AQI_POOR_ON: rd_val = thr_q.aqi_poor_on;
			aqlc_pkg::REG_AQI_HAZARD_ON: rd_val = thr_q.aqi_hazard_on;
			aqlc_pkg::REG_AQI_POOR_OFF: rd_val = thr_q.aqi_poor_off;
			default: rd_val = '0;
		endcase
	end

	assign prdata = {18'd0, rd_val};

endmodule

FILE: design/aqlc_score.sv
// Hazard score arithmetic of the air quality level classifier.
module aqlc_score (
	input  aqlc_pkg::aqlc_item_t  item,
	output aqlc_pkg::aqlc_score_t score
);

	logic signed [aqlc_pkg::RAW_W-1:0] ppm_s;
	logic signed [aqlc_pkg::RAW_W-1:0] aqi_s;
	logic signed [aqlc_pkg::RAW_W-1:0] hum_s;
	logic signed [aqlc_pkg::RAW_W-1:0] hdev_s;
	logic signed [aqlc_pkg::RAW_W-1:0] t_dev;
	logic signed [aqlc_pkg::RAW_W-1:0] co_raw;
	logic signed [aqlc_pkg::RAW_W-1:0] aqi_raw;
	logic [6:0] hdev;

	assign ppm_s = $signed({8'd0, item.co_ppm});
	assign aqi_s = $signed({10'd0, item.aqi_value});
	assign hum_s = $signed({13'd0, item.hum_pct});
	assign hdev = (item.hum_pct > aqlc_pkg::HUM_CO_REF) ?
		(item.hum_pct - aqlc_pkg::HUM_CO_REF) : 7'd0;
	assign hdev_s = $signed({13'd0, hdev});
	assign t_dev = 20'(item.temp_c) - aqlc_pkg::TEMP_REF;

	assign co_raw = ppm_s * aqlc_pkg::CO_PPM_GAIN + t_dev * aqlc_pkg::CO_TEMP_GAIN
		+ hdev_s * aqlc_pkg::CO_HUM_GAIN - aqlc_pkg::CO_OFFSET;
	assign aqi_raw = aqi_s * aqlc_pkg::AQI_GAIN + t_dev * aqlc_pkg::AQI_TEMP_GAIN
		+ (hum_s - aqlc_pkg::HUM_AQI_REF) * aqlc_pkg::AQI_HUM_GAIN - aqlc_pkg::AQI_OFFSET;

	always_comb begin
		if (co_raw < 0) begin
			score.co = '0;
		end else if (co_raw > aqlc_pkg::CO_RISK_MAX) begin
			score.co = aqlc_pkg::CO_RISK_MAX[aqlc_pkg::SCORE_W-1:0];
		end else begin
			score.co = co_raw[aqlc_pkg::SCORE_W-1:0];
		end
		if (aqi_raw < 0) begin
			score.aqi = '0;
		end else if (aqi_raw > aqlc_pkg::AQI_RISK_MAX) begin
			score.aqi = aqlc_pkg::AQI_RISK_MAX[aqlc_pkg::SCORE_W-1:0];
		end else begin
			score.aqi = aqi_raw[aqlc_pkg::SCORE_W-1:0];
		end
	end

endmodule

FILE: design/aqlc_ctrl.sv
// Level, alarm and blink state with the result register.
module aqlc_ctrl #(
	parameter int unsigned ON_TICKS = 10,
	parameter int unsigned OFF_TICKS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  aqlc_pkg::aqlc_item_t  item_s1,
	input  aqlc_pkg::aqlc_score_t score,
	input  aqlc_pkg::aqlc_thr_t   thr,
	output logic                  take,
	aqlc_out_if.source            result
);

	localparam int unsigned CNT_W = $clog2(ON_TICKS + OFF_TICKS);
	localparam logic [CNT_W:0] PERIOD = (CNT_W + 1)'(ON_TICKS + OFF_TICKS);
	localparam logic [CNT_W-1:0] ON_LIMIT = CNT_W'(ON_TICKS);

	aqlc_pkg::aqlc_level_t level_q;
	aqlc_pkg::aqlc_level_t level_d;
	aqlc_pkg::aqlc_level_t pick;
	logic alarm_q;
	logic alarm_d;
	logic [CNT_W-1:0] blink_q;
	logic [CNT_W-1:0] blink_d;
	logic [CNT_W:0] blink_inc;
	logic buzzer_q;
	logic buzzer_d;
	logic [aqlc_pkg::SCORE_W-1:0] cs;
	logic [aqlc_pkg::SCORE_W-1:0] as_val;
	logic out_valid_q;
	logic [1:0] air_level_q;
	logic buzzer_on_q;
	logic [aqlc_pkg::SCORE_W-1:0] co_risk_q;
	logic [aqlc_pkg::SCORE_W-1:0] aqi_risk_q;

	assign take = valid_s1 && (!out_valid_q || result.ready);
	assign blink_inc = {1'b0, blink_q} + 1'b1;

	always_comb begin
		if (cs >= thr.co_hazard_on || as_val >= thr.aqi_hazard_on) begin
			pick = aqlc_pkg::LVL_HAZARD;
		end else if (cs >= thr.co_poor_on || as_val >= thr.aqi_poor_on) begin
			pick = aqlc_pkg::LVL_POOR;
		end else if (cs >= thr.co_moderate_on || as_val >= thr.aqi_moderate_on) begin
			pick = aqlc_pkg::LVL_MODERATE;
		end else begin
			pick = aqlc_pkg::LVL_GOOD;
		end
		// A drop from poor to moderate holds at poor while either score stays high.
		if (level_q == aqlc_pkg::LVL_POOR && pick == aqlc_pkg::LVL_MODERATE &&
				(cs >= thr.co_poor_off || as_val >= thr.aqi_poor_off)) begin
			pick = aqlc_pkg::LVL_POOR;
		end
	end

	always_comb begin
		level_d = level_q;
		alarm_d = alarm_q;
		blink_d = blink_q;
		buzzer_d = buzzer_q;
		cs = '0;
		as_val = '0;
		if (item_s1.op == aqlc_pkg::OP_READING) begin
			cs = score.co;
			as_val = score.aqi;
			level_d = pick;
			if (pick == aqlc_pkg::LVL_POOR || pick == aqlc_pkg::LVL_HAZARD) begin
				alarm_d = 1'b1;
			end else begin
				alarm_d = 1'b0;
				buzzer_d = 1'b0;
			end
		end else if (alarm_q) begin
			if (blink_inc >= PERIOD) begin
				blink_d = '0;
			end else begin
				blink_d = blink_inc[CNT_W-1:0];
			end
			buzzer_d = (blink_d < ON_LIMIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= aqlc_pkg::LVL_GOOD;
			alarm_q <= 1'b0;
			blink_q <= '0;
			buzzer_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				level_q <= level_d;
				alarm_q <= alarm_d;
				blink_q <= blink_d;
				buzzer_q <= buzzer_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			air_level_q <= level_d;
			buzzer_on_q <= buzzer_d;
			co_risk_q <= cs;
			aqi_risk_q <= as_val;
		end
	end

	assign result.valid = out_valid_q;
	assign result.air_level = air_level_q;
	assign result.buzzer_on = buzzer_on_q;
	assign result.co_risk = co_risk_q;
	assign result.aqi_risk = aqi_risk_q;

endmodule

FILE: design/air_quality_level_classifier.sv
// Top level of the air quality level classifier.
// An accepted item is held in the input stage register, and its result is written to the output
// register when that register is free or being taken, so a busy output holds it in the input stage.
// One item per cycle is taken while the output register is free or being taken.
// arst_n clears the level, alarm, blink and handshake state and loads threshold defaults.
`include "air_quality_level_classifier_assert.svh"

module air_quality_level_classifier #(
	parameter int unsigned ON_TICKS = 10,
	parameter int unsigned OFF_TICKS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	aqlc_in_if.sink                     reading,
	aqlc_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aqlc_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	aqlc_pkg::aqlc_thr_t thr;
	aqlc_pkg::aqlc_item_t item_s1;
	aqlc_pkg::aqlc_score_t score;
	logic valid_s1;
	logic take;
	logic accept;

	assign reading.ready = !valid_s1 || take;
	assign accept = reading.valid && reading.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op <= reading.op;
			item_s1.co_ppm <= reading.co_ppm;
			item_s1.aqi_value <= reading.aqi_value;
			item_s1.temp_c <= reading.temp_c;
			item_s1.hum_pct <= reading.hum_pct;
		end
	end

	aqlc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr)
	);

	aqlc_score u_score (
		.item  (item_s1),
		.score (score)
	);

	aqlc_ctrl #(
		.ON_TICKS  (ON_TICKS),
		.OFF_TICKS (OFF_TICKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.score    (score),
		.thr      (thr),
		.take     (take),
		.result   (result)
	);

	`AQLC_ASSERT_NOW(a_quiet_when_low, result.valid && (result.air_level == aqlc_pkg::LVL_GOOD || result.air_level == aqlc_pkg::LVL_MODERATE), !result.buzzer_on, "Buzzer is on below poor level.")
	`AQLC_ASSERT_NOW(a_score_bounds, result.valid, result.co_risk <= 14'd10000 && result.aqi_risk <= 14'd15000, "Score exceeds its clamp.")
	`AQLC_ASSERT_NEXT(a_stage_holds, valid_s1 && !take, valid_s1, "Stalled input stage lost its item.")

endmodule

FILE: tb/air_quality_level_classifier_tb.sv
// Self-checking testbench for the air quality level classifier: directed and random items.
`timescale 1ns / 100ps

module air_quality_level_classifier_tb;

	localparam int unsigned ON_TICKS = 10;
	localparam int unsigned OFF_TICKS = 10;

	typedef struct packed {
		aqlc_pkg::aqlc_level_t lvl;
		logic buzz;
		logic [aqlc_pkg::SCORE_W-1:0] co;
		logic [aqlc_pkg::SCORE_W-1:0] aqi;
	} air_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [aqlc_pkg::APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	aqlc_in_if rd_if ();
	aqlc_out_if res_if ();

	air_quality_level_classifier #(
		.ON_TICKS(ON_TICKS),
		.OFF_TICKS(OFF_TICKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.reading(rd_if),
		.result(res_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	aqlc_pkg::aqlc_thr_t thr_model;
	aqlc_pkg::aqlc_level_t air_lvl;
	bit alarm_en;
	bit buzz_lvl;
	int unsigned blink_cnt;

	air_result_t pending_results[$];
	int unsigned mismatches;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit stall_req;
	int unsigned stall_left;

	always #4 clk = ~clk;

	function automatic air_result_t classify_item(aqlc_pkg::aqlc_item_t it);
		int t;
		int h;
		int co_raw;
		int aqi_raw;
		int unsigned cs;
		int unsigned as_v;
		aqlc_pkg::aqlc_level_t nxt;
		air_result_t r;
		cs = 0;
		as_v = 0;
		if (it.op == aqlc_pkg::OP_READING) begin
			t = int'($signed(it.temp_c));
			h = int'(it.hum_pct);
			co_raw = 50 * int'(it.co_ppm) + 5 * (t - 20) + 2 * ((h > 60) ? h - 60 : 0) - 500;
			aqi_raw = 40 * int'(it.aqi_value) + 3 * (t - 20) + 2 * (h - 50) - 300;
			cs = (co_raw < 0) ? 0 : (co_raw > 10000) ? 10000 : co_raw;
			as_v = (aqi_raw < 0) ? 0 : (aqi_raw > 15000) ? 15000 : aqi_raw;
			if (cs >= thr_model.co_hazard_on || as_v >= thr_model.aqi_hazard_on) begin
				nxt = aqlc_pkg::LVL_HAZARD;
			end else if (cs >= thr_model.co_poor_on || as_v >= thr_model.aqi_poor_on) begin
				nxt = aqlc_pkg::LVL_POOR;
			end else if (cs >= thr_model.co_moderate_on
					|| as_v >= thr_model.aqi_moderate_on) begin
				nxt = aqlc_pkg::LVL_MODERATE;
			end else begin
				nxt = aqlc_pkg::LVL_GOOD;
			end
			// A drop from poor to moderate is held while either score is at or above its off threshold.
			if (air_lvl == aqlc_pkg::LVL_POOR && nxt == aqlc_pkg::LVL_MODERATE &&
			    (cs >= thr_model.co_poor_off || as_v >= thr_model.aqi_poor_off)) begin
				nxt = aqlc_pkg::LVL_POOR;
			end
			air_lvl = nxt;
			if (nxt == aqlc_pkg::LVL_POOR || nxt == aqlc_pkg::LVL_HAZARD) begin
				alarm_en = 1'b1;
			end else begin
				alarm_en = 1'b0;
				buzz_lvl = 1'b0;
			end
		end else if (alarm_en) begin
			blink_cnt++;
			if (blink_cnt >= ON_TICKS + OFF_TICKS) begin
				blink_cnt = 0;
			end
			buzz_lvl = (blink_cnt < ON_TICKS);
		end
		r.lvl = air_lvl;
		r.buzz = buzz_lvl;
		r.co = cs[aqlc_pkg::SCORE_W-1:0];
		r.aqi = as_v[aqlc_pkg::SCORE_W-1:0];
		return r;
	endfunction

	function automatic void check_field(string fld, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, fld, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : predict_accepted
		aqlc_pkg::aqlc_item_t it;
		if (arst_n && rd_if.valid && rd_if.ready) begin
			it.op = rd_if.op;
			it.co_ppm = rd_if.co_ppm;
			it.aqi_value = rd_if.aqi_value;
			it.temp_c = rd_if.temp_c;
			it.hum_pct = rd_if.hum_pct;
			pending_results.push_back(classify_item(it));
		end
	end

	always @(posedge clk) begin : result_check
		air_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result level %0d buzzer %0d co %0d aqi %0d", $time,
					res_if.air_level, res_if.buzzer_on, res_if.co_risk, res_if.aqi_risk);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("air_level", want.lvl, res_if.air_level);
				check_field("buzzer_on", want.buzz, res_if.buzzer_on);
				check_field("co_risk", want.co, res_if.co_risk);
				check_field("aqi_risk", want.aqi, res_if.aqi_risk);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_req) begin
			stall_left = 200;
			stall_req = 1'b0;
		end
		if (stall_left != 0) begin
			stall_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic aqlc_pkg::aqlc_item_t noise_item();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(aqlc_pkg::aqlc_item_t)-1:0];
	endfunction

	function automatic aqlc_pkg::aqlc_item_t mk_tick();
		aqlc_pkg::aqlc_item_t it;
		it = noise_item();
		it.op = aqlc_pkg::OP_TICK;
		return it;
	endfunction

	function automatic aqlc_pkg::aqlc_item_t mk_reading(int ppm, int aqi, int t, int h);
		aqlc_pkg::aqlc_item_t it;
		it.op = aqlc_pkg::OP_READING;
		it.co_ppm = ppm[11:0];
		it.aqi_value = aqi[9:0];
		it.temp_c = t[7:0];
		it.hum_pct = h[6:0];
		return it;
	endfunction

	// Scores spread around the thresholds so that every level and the hold are reached.
	function automatic aqlc_pkg::aqlc_item_t shaped_reading();
		return mk_reading($urandom_range(0, 230), $urandom_range(0, 400),
			int'($urandom_range(0, 165)) - 40, $urandom_range(0, 100));
	endfunction

	task automatic send_item(aqlc_pkg::aqlc_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			rd_if.valid <= 1'b0;
			@(posedge clk);
		end
		rd_if.valid <= 1'b1;
		rd_if.op <= it.op;
		rd_if.co_ppm <= it.co_ppm;
		rd_if.aqi_value <= it.aqi_value;
		rd_if.temp_c <= it.temp_c;
		rd_if.hum_pct <= it.hum_pct;
		do @(posedge clk); while (!rd_if.ready);
	endtask

	task automatic drain();
		rd_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & 32'hFFFF_C000) | (val & 32'h0000_3FFF);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			aqlc_pkg::REG_CO_MODERATE_ON:
				thr_model.co_moderate_on = val[aqlc_pkg::SCORE_W-1:0];
			aqlc_pkg::REG_CO_POOR_ON: thr_model.co_poor_on = val[aqlc_pkg::SCORE_W-1:0];
			aqlc_pkg::REG_CO_HAZARD_ON: thr_model.co_hazard_on = val[aqlc_pkg::SCORE_W-1:0];
			aqlc_pkg::REG_CO_POOR_OFF: thr_model.co_poor_off = val[aqlc_pkg::SCORE_W-1:0];
			aqlc_pkg::REG_AQI_MODERATE_ON:
				thr_model.aqi_moderate_on = val[aqlc_pkg::SCORE_W-1:0];
			aqlc_pkg::REG_AQI_POOR_ON: thr_model.aqi_poor_on = val[aqlc_pkg::SCORE_W-1:0];
			aqlc_pkg::REG_AQI_HAZARD_ON:
				thr_model.aqi_hazard_on = val[aqlc_pkg::SCORE_W-1:0];
			aqlc_pkg::REG_AQI_POOR_OFF: thr_model.aqi_poor_off = val[aqlc_pkg::SCORE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_thresholds(int unsigned co_mod, int unsigned co_poor, int unsigned co_haz,
		int unsigned co_off, int unsigned aqi_mod, int unsigned aqi_poor, int unsigned aqi_haz,
		int unsigned aqi_off);
		write_reg(aqlc_pkg::REG_CO_MODERATE_ON, co_mod);
		write_reg(aqlc_pkg::REG_CO_POOR_ON, co_poor);
		write_reg(aqlc_pkg::REG_CO_HAZARD_ON, co_haz);
		write_reg(aqlc_pkg::REG_CO_POOR_OFF, co_off);
		write_reg(aqlc_pkg::REG_AQI_MODERATE_ON, aqi_mod);
		write_reg(aqlc_pkg::REG_AQI_POOR_ON, aqi_poor);
		write_reg(aqlc_pkg::REG_AQI_HAZARD_ON, aqi_haz);
		write_reg(aqlc_pkg::REG_AQI_POOR_OFF, aqi_off);
	endtask

	task automatic run_random(int unsigned n_items);
		int unsigned sent;
		int unsigned burst;
		int unsigned pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_item(shaped_reading());
				sent++;
			end else if (pick < 85) begin
				burst = $urandom_range(1, 30);
				repeat (burst) send_item(mk_tick());
				sent += burst;
			end else begin
				send_item(noise_item());
				sent++;
			end
		end
	endtask

	// Default thresholds: extremes of every field, hold at poor, blink kept across disable.
	task automatic test_directed();
		send_idle_pct = 7;
		recv_idle_pct = 82;
		send_item(mk_reading(0, 0, 0, 0));
		send_item(mk_tick());
		send_item(mk_reading(4095, 1023, 127, 127));
		send_item(mk_tick());
		send_item(mk_tick());
		send_item(mk_reading(110, 0, 20, 50));
		send_item(mk_reading(102, 0, 20, 50));
		send_item(mk_reading(0, 210, 20, 50));
		send_item(mk_reading(90, 0, 20, 50));
		send_item(mk_tick());
		send_item(mk_reading(0, 233, 20, 50));
		send_item(mk_tick());
		send_item(mk_reading(0, 0, -128, 0));
		send_item(mk_reading(0, 0, -40, 100));
		send_item(mk_reading(0, 1023, 125, 100));
		send_item(mk_reading(4095, 0, -40, 0));
		send_item(mk_reading(10, 8, 20, 61));
		send_item(mk_reading(10, 8, 20, 60));
		send_item(mk_reading(1, 1023, -128, 127));
		send_item(mk_tick());
	endtask

	task automatic test_reset_thresholds();
		send_idle_pct = 7;
		recv_idle_pct = 82;
		run_random(500);
	endtask

	task automatic test_zero_thresholds();
		drain();
		send_idle_pct = 82;
		recv_idle_pct = 7;
		set_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
		run_random(150);
	endtask

	task automatic test_saturated_thresholds();
		drain();
		send_idle_pct = 82;
		recv_idle_pct = 7;
		set_thresholds(10000, 10000, 10000, 16383, 15000, 15000, 15000, 16383);
		run_random(150);
	endtask

	task automatic test_random_thresholds();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (3) begin
			drain();
			set_thresholds($urandom_range(0, 10000), $urandom_range(0, 10000),
				$urandom_range(0, 10000), $urandom_range(0, 10000),
				$urandom_range(0, 15000), $urandom_range(0, 15000),
				$urandom_range(0, 15000), $urandom_range(0, 15000));
			run_random(120);
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_req = 1'b1;
		repeat (30) begin
			send_item(shaped_reading());
			send_item(mk_tick());
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rd_if.valid = 1'b0;
		rd_if.op = aqlc_pkg::OP_READING;
		rd_if.co_ppm = '0;
		rd_if.aqi_value = '0;
		rd_if.temp_c = '0;
		rd_if.hum_pct = '0;
		res_if.ready = 1'b0;
		stall_req = 1'b0;
		stall_left = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		air_lvl = aqlc_pkg::LVL_GOOD;
		alarm_en = 1'b0;
		buzz_lvl = 1'b0;
		blink_cnt = 0;
		thr_model = '{
			co_moderate_on: aqlc_pkg::RST_CO_MODERATE_ON,
			co_poor_on: aqlc_pkg::RST_CO_POOR_ON,
			co_hazard_on: aqlc_pkg::RST_CO_HAZARD_ON,
			co_poor_off: aqlc_pkg::RST_CO_POOR_OFF,
			aqi_moderate_on: aqlc_pkg::RST_AQI_MODERATE_ON,
			aqi_poor_on: aqlc_pkg::RST_AQI_POOR_ON,
			aqi_hazard_on: aqlc_pkg::RST_AQI_HAZARD_ON,
			aqi_poor_off: aqlc_pkg::RST_AQI_POOR_OFF
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_reset_thresholds();
		test_zero_thresholds();
		test_saturated_thresholds();
		test_random_thresholds();
		test_backpressure();
		drain();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: air_quality_level_classifier.f
+incdir+design
design/aqlc_pkg.sv
design/aqlc_if.sv
design/aqlc_regs.sv
design/aqlc_score.sv
design/aqlc_ctrl.sv
design/air_quality_level_classifier.sv
tb/air_quality_level_classifier_tb.sv
